[design/hhm_pkg.sv]
// Package for the heartbeat health monitor: request types, health and mode codes.
// Used by heartbeat_health_monitor_unit; no dependencies.
package hhm_pkg;

  localparam int NUM_SUBSYS = 8;
  localparam int IDX_W      = (NUM_SUBSYS > 1) ? $clog2(NUM_SUBSYS) : 1;

  localparam logic [1:0] H_OK       = 2'd0;
  localparam logic [1:0] H_DEGRADED = 2'd1;
  localparam logic [1:0] H_FAILED   = 2'd2;
  localparam logic [1:0] H_UNKNOWN  = 2'd3;

  localparam logic [1:0] MODE_REGISTER = 2'd0;
  localparam logic [1:0] MODE_FORCE    = 2'd1;
  localparam logic [1:0] MODE_ALIVE    = 2'd2;
  localparam logic [1:0] MODE_TICK     = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  subsys_id;
    logic [1:0]  forced_state;
    logic [31:0] timeout_ms;
    logic [47:0] now_ms;
  } in_req_t;

  typedef struct packed {
    logic [2:0] changed_id;
    logic [1:0] new_health;
    logic [1:0] overall_health;
    logic       last;
  } out_req_t;

endpackage

[design/heartbeat_health_monitor_unit.sv]
// Heartbeat health monitor: one sequencer around a shared 49-bit subtractor.
// Register and alive requests complete in the idle state; force goes through apply and flush;
// a poll tick walks the table one entry at a time (age, compare with twice the
// timeout, compare with the timeout, update), and a stalled output holds it.
// One request is in work at a time.
// Reset clears the registered flags, the sequencer and the pending and output valid flags.
module heartbeat_health_monitor_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  hhm_pkg::in_req_t in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output hhm_pkg::out_req_t out_req_o
);
  import hhm_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_AGE   = 3'd1;
  localparam logic [2:0] ST_CMP2  = 3'd2;
  localparam logic [2:0] ST_CMP1  = 3'd3;
  localparam logic [2:0] ST_APPLY = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SUBSYS - 1);

  logic [2:0] state_q, state_d;
  logic [NUM_SUBSYS-1:0] reg_q, reg_d;
  logic [1:0]  health_q  [NUM_SUBSYS];
  logic [31:0] timeout_q [NUM_SUBSYS];
  logic [47:0] seen_q    [NUM_SUBSYS];

  logic [IDX_W-1:0] idx_q, idx_d;
  logic             tick_q, tick_d;
  logic [47:0]      now_q, now_d;
  logic [47:0]      age_q, age_d;
  logic [1:0]       st_q, st_d;

  logic     pend_vld_q, pend_vld_d;
  out_req_t pend_q, pend_d;
  logic     out_vld_q, out_vld_d;
  out_req_t out_q, out_d;

  // shared subtractor
  logic [48:0] sub_a, sub_b;
  logic [49:0] sub_diff;
  logic        sub_borrow;

  logic        in_acc;
  logic        out_free;
  logic        id_ok;
  logic [IDX_W-1:0] in_idx;
  logic        eligible;
  logic        change;
  logic [1:0]  worst_new;

  // health table writes
  logic             h_we;
  logic [IDX_W-1:0] h_widx;
  logic [1:0]       h_wdata;
  logic             reg_we;
  logic             seen_we;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_vld_q || !out_stall_i;
  assign id_ok    = int'(in_req_i.subsys_id) < NUM_SUBSYS;
  assign in_idx   = in_req_i.subsys_id[IDX_W-1:0];

  assign eligible = reg_q[idx_q] && (timeout_q[idx_q] != 32'd0) && (seen_q[idx_q] != 48'd0);
  assign change   = reg_q[idx_q] && (health_q[idx_q] != st_q);

  assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_diff[49];

  always_comb begin
    unique case (state_q)
      ST_CMP2: begin
        sub_a = {16'd0, timeout_q[idx_q], 1'b0};
        sub_b = {1'b0, age_q};
      end
      ST_CMP1: begin
        sub_a = {17'd0, timeout_q[idx_q]};
        sub_b = {1'b0, age_q};
      end
      default: begin
        sub_a = {1'b0, now_q};
        sub_b = {1'b0, seen_q[idx_q]};
      end
    endcase
  end

  // worst registered state, taking the pending update of idx_q into account
  always_comb begin
    logic [1:0] h;
    worst_new = H_OK;
    for (int i = 0; i < NUM_SUBSYS; i++) begin
      h = (IDX_W'(i) == idx_q) ? st_q : health_q[i];
      if (reg_q[i] && (h > worst_new)) begin
        worst_new = h;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    tick_d     = tick_q;
    now_d      = now_q;
    age_d      = age_q;
    st_d       = st_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    reg_d      = reg_q;
    h_we       = 1'b0;
    h_widx     = idx_q;
    h_wdata    = st_q;
    reg_we     = 1'b0;
    seen_we    = 1'b0;

    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          now_d = in_req_i.now_ms;
          if (in_req_i.mode == MODE_TICK) begin
            tick_d  = 1'b1;
            idx_d   = '0;
            state_d = ST_AGE;
          end else if (id_ok) begin
            tick_d = 1'b0;
            idx_d  = in_idx;
            unique case (in_req_i.mode)
              MODE_REGISTER: begin
                reg_we         = 1'b1;
                reg_d[in_idx]  = 1'b1;
                h_we           = 1'b1;
                h_widx         = in_idx;
                h_wdata        = H_UNKNOWN;
              end
              MODE_FORCE: begin
                st_d    = in_req_i.forced_state;
                state_d = ST_APPLY;
              end
              default: begin
                seen_we = 1'b1;
              end
            endcase
          end
        end
      end
      ST_AGE: begin
        if (!eligible) begin
          if (idx_q == LAST_IDX) begin
            state_d = ST_FLUSH;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end else if (sub_borrow || (sub_diff[47:0] == 48'd0)) begin
          // clock not ahead of last beat
          st_d    = H_OK;
          state_d = ST_APPLY;
        end else begin
          age_d   = sub_diff[47:0];
          state_d = ST_CMP2;
        end
      end
      ST_CMP2: begin
        if (sub_borrow) begin
          st_d    = H_FAILED;
          state_d = ST_APPLY;
        end else begin
          state_d = ST_CMP1;
        end
      end
      ST_CMP1: begin
        st_d    = sub_borrow ? H_DEGRADED : H_OK;
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        if (!change || !pend_vld_q || out_free) begin
          if (change) begin
            if (pend_vld_q) begin
              out_vld_d = 1'b1;
              out_d     = pend_q;
            end
            pend_vld_d            = 1'b1;
            pend_d.changed_id     = 3'(idx_q);
            pend_d.new_health     = st_q;
            pend_d.overall_health = worst_new;
            pend_d.last           = 1'b0;
            h_we                  = 1'b1;
          end
          if (!tick_q || (idx_q == LAST_IDX)) begin
            state_d = ST_FLUSH;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_AGE;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_vld_d  = 1'b1;
          out_d      = pend_q;
          out_d.last = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      reg_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      idx_q      <= '0;
      tick_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      reg_q      <= reg_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      idx_q      <= idx_d;
      tick_q     <= tick_d;
    end
  end

  // payload, no reset needed: entries are only read once registered
  always_ff @(posedge clk_i) begin
    now_q  <= now_d;
    age_q  <= age_d;
    st_q   <= st_d;
    pend_q <= pend_d;
    out_q  <= out_d;
    if (h_we) begin
      health_q[h_widx] <= h_wdata;
    end
    if (reg_we) begin
      timeout_q[in_idx] <= in_req_i.timeout_ms;
      seen_q[in_idx]    <= 48'd0;
    end
    if (seen_we) begin
      seen_q[in_idx] <= in_req_i.now_ms;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_req_o   = out_q;

endmodule

[bench/heartbeat_health_monitor_unit_tb.sv]
// Self-checking bench for heartbeat_health_monitor_unit: directed, random and backpressure tests.
// Predicts every health change in-bench; depends on hhm_pkg and the unit only.
module heartbeat_health_monitor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hhm_pkg::*;

  localparam int SCAN_CYCLES = 4 * NUM_SUBSYS + 2;
  localparam int STUCK_LIMIT = 3000;
  localparam int LONG_HOLD   = 150;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  in_req_t  in_req_i    = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_req_t out_req_o;

  heartbeat_health_monitor_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the subsystem table
  logic        mon_regd   [NUM_SUBSYS];
  logic [1:0]  mon_health [NUM_SUBSYS];
  logic [31:0] mon_tmo    [NUM_SUBSYS];
  logic [47:0] mon_seen   [NUM_SUBSYS];

  out_req_t health_changes_q[$];
  out_req_t req_changes[$];

  int  err_cnt      = 0;
  int  change_cnt   = 0;
  int  mode_cnt[4]  = '{default: 0};
  int  hold_cycles  = 0;
  int  stuck_cycles = 0;
  bit  idle_en      = 1'b1;

  initial begin
    for (int i = 0; i < NUM_SUBSYS; i++) begin
      mon_regd[i]   = 1'b0;
      mon_health[i] = H_OK;
      mon_tmo[i]    = '0;
      mon_seen[i]   = '0;
    end
  end

  function automatic logic [1:0] worst_registered();
    logic [1:0] w;
    w = H_OK;
    for (int i = 0; i < NUM_SUBSYS; i++) begin
      if (mon_regd[i] && mon_health[i] > w) w = mon_health[i];
    end
    return w;
  endfunction

  function automatic void record_change(int id, logic [1:0] st);
    out_req_t c;
    mon_health[id]   = st;
    c.changed_id     = 3'(id);
    c.new_health     = st;
    c.overall_health = worst_registered();
    c.last           = 1'b0;
    req_changes.push_back(c);
  endfunction

  function automatic void predict_health_changes(in_req_t r);
    int          id;
    logic [1:0]  st;
    logic [48:0] age;
    id = int'(r.subsys_id);
    req_changes.delete();
    if (r.mode == MODE_TICK) begin
      for (int i = 0; i < NUM_SUBSYS; i++) begin
        if (!mon_regd[i] || mon_tmo[i] == '0 || mon_seen[i] == '0) continue;
        if (r.now_ms <= mon_seen[i]) begin
          st = H_OK;
        end else begin
          age = {1'b0, r.now_ms} - {1'b0, mon_seen[i]};
          // doubled timeout kept at full width
          if (age > {16'd0, mon_tmo[i], 1'b0}) st = H_FAILED;
          else if (age > {17'd0, mon_tmo[i]}) st = H_DEGRADED;
          else st = H_OK;
        end
        if (mon_health[i] != st) record_change(i, st);
      end
    end else if (id < NUM_SUBSYS) begin
      case (r.mode)
        MODE_REGISTER: begin
          mon_regd[id]   = 1'b1;
          mon_health[id] = H_UNKNOWN;
          mon_tmo[id]    = r.timeout_ms;
          mon_seen[id]   = '0;
        end
        MODE_FORCE: begin
          if (mon_regd[id] && mon_health[id] != r.forced_state) record_change(id, r.forced_state);
        end
        default: begin
          mon_seen[id] = r.now_ms;
        end
      endcase
    end
    if (req_changes.size() > 0) req_changes[req_changes.size() - 1].last = 1'b1;
    foreach (req_changes[k]) health_changes_q.push_back(req_changes[k]);
  endfunction

  function automatic in_req_t mk_req(logic [1:0] mode, int id, logic [1:0] fs,
                                     logic [31:0] tmo, logic [47:0] now);
    in_req_t r;
    r.mode         = mode;
    r.subsys_id    = 3'(id);
    r.forced_state = fs;
    r.timeout_ms   = tmo;
    r.now_ms       = now;
    return r;
  endfunction

  // Leaves valid high after acceptance; an idle gap before the next request, or wait_quiet, drops it.
  task automatic send_req(in_req_t r);
    int gap;
    gap = idle_en ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
    mode_cnt[r.mode]++;
    predict_health_changes(r);
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (health_changes_q.size() != 0) @(posedge clk_i);
    repeat (SCAN_CYCLES + 4) @(posedge clk_i);
  endtask

  function automatic void cmp_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
      err_cnt++;
    end
  endfunction

  task automatic check_change(out_req_t got);
    out_req_t exp_c;
    change_cnt++;
    if (health_changes_q.size() == 0) begin
      $display("%0t: unexpected change: expected none, got id %0d health %0d", $time,
               got.changed_id, got.new_health);
      err_cnt++;
    end else begin
      exp_c = health_changes_q.pop_front();
      cmp_field("changed_id", exp_c.changed_id, got.changed_id);
      cmp_field("new_health", exp_c.new_health, got.new_health);
      cmp_field("overall_health", exp_c.overall_health, got.overall_health);
      cmp_field("last", exp_c.last, got.last);
    end
  endtask

  // receiver: random hold per request, or one long hold when asked
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = idle_en ? $urandom_range(0, 3) : 0;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      check_change(out_req_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stuck_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: watchdog: no handshake for %0d cycles", $time, STUCK_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // age boundaries, wide timeout, time going back, never-seen entries
  task automatic test_directed_cases();
    send_req(mk_req(MODE_REGISTER, 0, H_OK, 32'd100, '0));
    send_req(mk_req(MODE_REGISTER, 7, H_OK, 32'hFFFF_FFFF, '0));
    send_req(mk_req(MODE_REGISTER, 3, H_OK, 32'd0, '0));
    send_req(mk_req(MODE_FORCE, 0, H_FAILED, '0, '0));
    send_req(mk_req(MODE_FORCE, 0, H_FAILED, '0, '0));     // unchanged
    send_req(mk_req(MODE_FORCE, 5, H_DEGRADED, '0, '0));   // unregistered
    send_req(mk_req(MODE_FORCE, 7, H_OK, '0, '0));
    send_req(mk_req(MODE_FORCE, 0, H_DEGRADED, '0, '0));
    send_req(mk_req(MODE_FORCE, 3, H_UNKNOWN, '0, '0));
    send_req(mk_req(MODE_ALIVE, 0, H_OK, '0, 48'd1000));
    send_req(mk_req(MODE_ALIVE, 7, H_OK, '0, 48'd10));
    send_req(mk_req(MODE_ALIVE, 3, H_OK, '0, 48'd5));      // disarmed entry
    send_req(mk_req(MODE_ALIVE, 5, H_OK, '0, 48'd500));    // unregistered, still stamped
    send_req(mk_req(MODE_TICK, 0, H_OK, '0, 48'd1100));    // age == timeout
    send_req(mk_req(MODE_TICK, 0, H_OK, '0, 48'd1101));
    send_req(mk_req(MODE_TICK, 0, H_OK, '0, 48'd1200));    // age == 2*timeout
    send_req(mk_req(MODE_TICK, 0, H_OK, '0, 48'd1201));
    send_req(mk_req(MODE_TICK, 0, H_OK, '0, 48'd900));     // clock went back
    send_req(mk_req(MODE_TICK, 0, H_OK, '0, 48'h1_FFFF_FFFF + 48'd10)); // wide 2*timeout edge
    send_req(mk_req(MODE_TICK, 0, H_OK, '0, 48'hFFFF_FFFF_FFFF));
    send_req(mk_req(MODE_ALIVE, 0, H_OK, '0, 48'd0));      // back to never seen
    send_req(mk_req(MODE_REGISTER, 5, H_OK, 32'd1, '0));   // clears earlier stamp
    send_req(mk_req(MODE_TICK, 0, H_OK, '0, 48'hFFFF_FFFF_FFFF));
    wait_quiet();
  endtask

  // register a set, then alive/tick streams with a rising clock and some noise
  task automatic test_heartbeat_sessions();
    logic [47:0] base;
    logic [31:0] tmo;
    int          pick;
    for (int s = 0; s < 12; s++) begin
      idle_en = !(s == 4 || s == 5);
      base = ($urandom_range(0, 3) == 0) ? {1'b0, 15'($urandom), 32'($urandom)}
                                         : 48'($urandom_range(1, 1000));
      repeat ($urandom_range(1, 8)) begin
        pick = $urandom_range(0, 9);
        tmo  = (pick == 0) ? 32'd0 : (pick == 1) ? 32'($urandom) : 32'($urandom_range(1, 40));
        send_req(mk_req(MODE_REGISTER, $urandom_range(0, 7), H_OK, tmo, '0));
      end
      repeat (20) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          send_req(mk_req(MODE_ALIVE, $urandom_range(0, 7), 2'($urandom), 32'($urandom), base));
        end else if (pick < 75) begin
          send_req(mk_req(MODE_TICK, $urandom_range(0, 7), 2'($urandom), 32'($urandom), base));
        end else if (pick < 85) begin
          send_req(mk_req(MODE_FORCE, $urandom_range(0, 7), 2'($urandom), '0, base));
        end else if (pick < 90) begin
          send_req(mk_req(MODE_REGISTER, $urandom_range(0, 7), H_OK,
                          32'($urandom_range(1, 40)), base));
        end else begin
          send_req(mk_req(MODE_TICK, 0, H_OK, '0, base - 48'($urandom_range(0, 20))));
        end
        base = base + 48'($urandom_range(0, 30));
      end
      wait_quiet();
    end
    idle_en = 1'b1;
  endtask

  // every tick flips all eight entries while the receiver holds off
  task automatic test_backpressure();
    for (int i = 0; i < NUM_SUBSYS; i++) begin
      send_req(mk_req(MODE_REGISTER, i, H_OK, 32'd10, '0));
      send_req(mk_req(MODE_ALIVE, i, H_OK, '0, 48'd100));
    end
    hold_cycles = LONG_HOLD;
    for (int k = 0; k < 8; k++) begin
      send_req(mk_req(MODE_TICK, 0, H_OK, '0, (k % 2 == 0) ? 48'd200 : 48'd105));
    end
    wait_quiet();
  endtask

  task automatic test_random_noise();
    repeat (40) begin
      send_req(mk_req(2'($urandom), $urandom_range(0, 7), 2'($urandom), 32'($urandom),
                      {16'($urandom), 32'($urandom)}));
    end
    wait_quiet();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_heartbeat_sessions();
    test_backpressure();
    test_random_noise();
    $display("Ran %0d register, %0d force, %0d alive and %0d tick requests; %0d changes checked,",
             mode_cnt[MODE_REGISTER], mode_cnt[MODE_FORCE], mode_cnt[MODE_ALIVE],
             mode_cnt[MODE_TICK], change_cnt);
    $display("with random gaps on both sides and one %0d-cycle output hold.", LONG_HOLD);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
design/hhm_pkg.sv
design/heartbeat_health_monitor_unit.sv
bench/heartbeat_health_monitor_unit_tb.sv
